### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and masked in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define FCPAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define FCPAC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/fcpac_pkg.sv
// ----------------------------------------------------------------------------
// fcpac_pkg
// Types, widths and constants of the full-circle point angle classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpac_pkg;

  localparam int COORD_BITS    = 32;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  // Center-relative differences carry one extra bit.
  localparam int DIFF_W      = COORD_BITS + 1;
  // Working width of the rotation datapath; vectors are normalized to bit NORM_TOP.
  localparam int WORK_W      = 64;
  localparam int NORM_TOP    = 59;
  localparam int NORM_STAGES = 6;
  localparam int SHIFT_W     = $clog2(WORK_W);
  localparam int STAGE_W     = 5;
  localparam int TURN_W      = 32;
  localparam int ROUND_SH    = TURN_W - ANGLE_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE   = CFG_IDX_W'(3);

  localparam logic [TURN_W-1:0] TURN_ZERO    = 32'h0000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_3QUART  = 32'hC000_0000;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
  localparam logic [TURN_W-1:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    CLASS_NONE     = 2'd0,
    CLASS_INITIAL  = 2'd1,
    CLASS_TERMINAL = 2'd2
  } endpoint_class_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    endpoint_class_e       endpoint_class;
  } out_beat_t;

  // Beat handed along the normalization cells.
  typedef struct packed {
    logic                     fixed;
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic        [WORK_W-1:0] m;
    logic        [TURN_W-1:0] z;
  } norm_beat_t;

  // Beat handed along the rotation cells.
  typedef struct packed {
    logic                     fixed;
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic        [TURN_W-1:0] z;
  } cordic_beat_t;

endpackage

`default_nettype wire

### rtl/fcpac_front.sv
// ----------------------------------------------------------------------------
// fcpac_front
// Center subtraction and half-turn prerotation into the right half plane.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpac_front (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      en_i,
  input  wire logic                                      valid_i,
  input  wire fcpac_pkg::in_beat_t                       beat_i,
  input  wire logic signed [fcpac_pkg::COORD_BITS-1:0]   center_x_i,
  input  wire logic signed [fcpac_pkg::COORD_BITS-1:0]   center_y_i,
  output logic                                           valid_o,
  output fcpac_pkg::norm_beat_t                          beat_o
);

  localparam int DW = fcpac_pkg::DIFF_W;
  localparam int WW = fcpac_pkg::WORK_W;

  logic                 diff_valid_q;
  logic signed [DW-1:0] dx_q, dx_d;
  logic signed [DW-1:0] dy_q, dy_d;

  logic                  rot_valid_q;
  fcpac_pkg::norm_beat_t rot_q, rot_d;

  logic signed [WW-1:0] dx_ext, dy_ext;
  logic        [WW-1:0] abs_x, abs_y;
  logic                 x_neg, x_zero, y_up;

  always_comb begin
    dx_d = {beat_i.point_x[fcpac_pkg::COORD_BITS-1], beat_i.point_x}
         - {center_x_i[fcpac_pkg::COORD_BITS-1], center_x_i};
    dy_d = {beat_i.point_y[fcpac_pkg::COORD_BITS-1], beat_i.point_y}
         - {center_y_i[fcpac_pkg::COORD_BITS-1], center_y_i};
  end

  always_comb begin
    dx_ext = {{(WW-DW){dx_q[DW-1]}}, dx_q};
    dy_ext = {{(WW-DW){dy_q[DW-1]}}, dy_q};
    x_neg  = dx_q[DW-1];
    x_zero = (dx_q == '0);
    y_up   = !dy_q[DW-1] && (dy_q != '0);
    abs_x  = x_neg ? WW'(-dx_ext) : WW'(dx_ext);
    abs_y  = dy_q[DW-1] ? WW'(-dy_ext) : WW'(dy_ext);

    rot_d.fixed = x_zero;
    rot_d.x     = x_neg ? -dx_ext : dx_ext;
    rot_d.y     = x_neg ? -dy_ext : dy_ext;
    rot_d.m     = (abs_x > abs_y) ? abs_x : abs_y;
    // A vertical vector takes its angle directly; rotation cells leave it alone.
    if (x_zero) begin
      rot_d.z = y_up ? fcpac_pkg::TURN_QUARTER : fcpac_pkg::TURN_3QUART;
    end else begin
      rot_d.z = x_neg ? fcpac_pkg::TURN_HALF : fcpac_pkg::TURN_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_valid_q <= 1'b0;
      rot_valid_q  <= 1'b0;
    end else if (en_i) begin
      diff_valid_q <= valid_i;
      rot_valid_q  <= diff_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      rot_q <= rot_d;
    end
  end

  assign valid_o = rot_valid_q;
  assign beat_o  = rot_q;

endmodule

`default_nettype wire

### rtl/fcpac_norm_cell.sv
// ----------------------------------------------------------------------------
// fcpac_norm_cell
// One step of the normalizing shift: shifts the vector left by a fixed amount
// when the magnitude bound stays below the normalization ceiling.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpac_norm_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic [fcpac_pkg::SHIFT_W-1:0]     shift_i,
  input  wire logic                              valid_i,
  input  wire fcpac_pkg::norm_beat_t             beat_i,
  output logic                                   valid_o,
  output fcpac_pkg::norm_beat_t                  beat_o
);

  localparam int LIMIT_W = fcpac_pkg::SHIFT_W + 1;

  logic                  valid_q;
  fcpac_pkg::norm_beat_t beat_q, beat_d;
  logic [LIMIT_W-1:0]    limit_sh;
  logic                  fits;

  always_comb begin
    // The shift is taken only if the bound stays below 2^(NORM_TOP+1).
    limit_sh = LIMIT_W'(fcpac_pkg::NORM_TOP + 1) - {1'b0, shift_i};
    fits     = ((beat_i.m >> limit_sh) == '0);
    beat_d   = beat_i;
    if (fits) begin
      beat_d.x = beat_i.x <<< shift_i;
      beat_d.y = beat_i.y <<< shift_i;
      beat_d.m = beat_i.m << shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

### rtl/fcpac_cordic_cell.sv
// ----------------------------------------------------------------------------
// fcpac_cordic_cell
// One vectoring micro-rotation: drives y toward zero and accumulates the
// rotated angle in turns.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpac_cordic_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic [fcpac_pkg::STAGE_W-1:0]     stage_i,
  input  wire logic                              valid_i,
  input  wire fcpac_pkg::cordic_beat_t           beat_i,
  output logic                                   valid_o,
  output fcpac_pkg::cordic_beat_t                beat_o
);

  localparam int WW = fcpac_pkg::WORK_W;

  logic                    valid_q;
  fcpac_pkg::cordic_beat_t beat_q, beat_d;
  logic signed [WW-1:0]    xs, ys;
  logic [fcpac_pkg::TURN_W-1:0] step;

  always_comb begin
    xs     = $signed(beat_i.x) >>> stage_i;
    ys     = $signed(beat_i.y) >>> stage_i;
    step   = fcpac_pkg::ATAN_TURN[stage_i];
    beat_d = beat_i;
    if (!beat_i.fixed) begin
      if (!beat_i.y[WW-1]) begin
        beat_d.x = beat_i.x + ys;
        beat_d.y = beat_i.y - xs;
        beat_d.z = beat_i.z + step;
      end else begin
        beat_d.x = beat_i.x - ys;
        beat_d.y = beat_i.y + xs;
        beat_d.z = beat_i.z - step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

### rtl/full_circle_point_angle_classify.sv
// ----------------------------------------------------------------------------
// full_circle_point_angle_classify
// Angle in [0, 2pi) from the configured center to a point, by a pipelined
// vectoring CORDIC, and classification against the arc's start and end.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------
//   in      | input     | in_valid/ready   | point_x, point_y
//   out     | output    | out_valid/ready  | angle, endpoint_class
//   cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
// One point is taken per cycle while in_ready_o is high; a result passes two
// front cells, six normalizing cells, sixteen rotation cells and the output
// register. A two-entry output stage (register plus skid) decouples the
// sides; in_ready_o is a register and drops only while the skid is full,
// which freezes the whole chain. Reset clears all valid bits and the
// configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module full_circle_point_angle_classify (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire fcpac_pkg::in_beat_t                   in_beat_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output fcpac_pkg::out_beat_t                       out_beat_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [fcpac_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fcpac_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int NS = fcpac_pkg::NORM_STAGES;
  localparam int CS = fcpac_pkg::CORDIC_STAGES;
  localparam int AW = fcpac_pkg::ANGLE_BITS;
  localparam int TW = fcpac_pkg::TURN_W;
  localparam logic [TW:0] ROUND_ADD = (TW+1)'((64'(1) << fcpac_pkg::ROUND_SH) >> 1);

  // Configuration registers.
  logic signed [fcpac_pkg::COORD_BITS-1:0] center_x_q, center_y_q;
  logic        [AW-1:0]                    start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      start_q    <= '0;
      end_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fcpac_pkg::CFG_CENTER_X:    center_x_q <= cfg_wdata_i[fcpac_pkg::COORD_BITS-1:0];
        fcpac_pkg::CFG_CENTER_Y:    center_y_q <= cfg_wdata_i[fcpac_pkg::COORD_BITS-1:0];
        fcpac_pkg::CFG_START_ANGLE: start_q    <= cfg_wdata_i[AW-1:0];
        fcpac_pkg::CFG_END_ANGLE:   end_q      <= cfg_wdata_i[AW-1:0];
        default: ;
      endcase
    end
  end

  // Chain enable: the whole row advances while the skid entry is free.
  logic en;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;
  fcpac_pkg::out_beat_t out_q, out_d, skid_q, skid_d;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  logic                    norm_valid [NS+1];
  fcpac_pkg::norm_beat_t   norm_beat  [NS+1];
  logic                    rot_valid  [CS+1];
  fcpac_pkg::cordic_beat_t rot_beat   [CS+1];

  fcpac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .beat_i     (in_beat_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (norm_valid[0]),
    .beat_o     (norm_beat[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_norm
    fcpac_norm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (fcpac_pkg::SHIFT_W'((fcpac_pkg::WORK_W / 2) >> g)),
      .valid_i (norm_valid[g]),
      .beat_i  (norm_beat[g]),
      .valid_o (norm_valid[g+1]),
      .beat_o  (norm_beat[g+1])
    );
  end

  assign rot_valid[0] = norm_valid[NS];
  assign rot_beat[0]  = '{fixed: norm_beat[NS].fixed, x: norm_beat[NS].x,
                          y: norm_beat[NS].y, z: norm_beat[NS].z};

  for (genvar g = 0; g < CS; g++) begin : g_rot
    fcpac_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (fcpac_pkg::STAGE_W'(g)),
      .valid_i (rot_valid[g]),
      .beat_i  (rot_beat[g]),
      .valid_o (rot_valid[g+1]),
      .beat_o  (rot_beat[g+1])
    );
  end

  // Round the turn accumulator to the output angle and classify it.
  logic [TW:0]          turn_sum;
  fcpac_pkg::out_beat_t result;

  always_comb begin
    turn_sum     = {1'b0, rot_beat[CS].z} + ROUND_ADD;
    result.angle = turn_sum[fcpac_pkg::ROUND_SH +: AW];
    if (result.angle == start_q) begin
      result.endpoint_class = fcpac_pkg::CLASS_INITIAL;
    end else if (result.angle == end_q) begin
      result.endpoint_class = fcpac_pkg::CLASS_TERMINAL;
    end else begin
      result.endpoint_class = fcpac_pkg::CLASS_NONE;
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_d = rot_valid[CS];
      out_d       = result;
    end else if (rot_valid[CS]) begin
      skid_valid_d = 1'b1;
      skid_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `FCPAC_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid holds a beat ahead of an empty output register")
  `FCPAC_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_q) |-> ($past(out_valid_q) && !$past(out_ready_i)), "skid filled without an output stall")
  `FCPAC_ASSERT(a_skid_holds, (skid_valid_q && out_valid_q && !out_ready_i) |=> (skid_valid_q && $stable(skid_q)), "skid beat changed while stalled")

endmodule

`default_nettype wire

### tb/tb_full_circle_point_angle_classify.sv
// ----------------------------------------------------------------------------
// tb_full_circle_point_angle_classify
// Self-checking bench for the point angle classifier. Points go in as bursts
// and each one is predicted from a bit-true vectoring CORDIC of its own. The
// output side stalls on changing patterns. Every result is checked, field by
// field, against the oldest prediction. Center and arc settings change
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_full_circle_point_angle_classify;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;

  // atan(2^-i) in units of 2^-32 turn, one entry per rotation stage.
  localparam logic [31:0] ATAN_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fcpac_pkg::in_beat_t in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fcpac_pkg::out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [fcpac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fcpac_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration registers.
  logic [31:0] ctr_x = '0;
  logic [31:0] ctr_y = '0;
  logic [15:0] arc_start = '0;
  logic [15:0] arc_end = '0;

  fcpac_pkg::in_beat_t point_q[$];
  fcpac_pkg::out_beat_t angle_q[$];

  int burst_left = 1;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int pat_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  full_circle_point_angle_classify DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic logic [fcpac_pkg::ANGLE_BITS-1:0] point_angle(fcpac_pkg::in_beat_t p,
                                                                   logic [31:0] cx,
                                                                   logic [31:0] cy);
    logic signed [63:0] dx, dy, x, y, xs, ys;
    logic [63:0] mag;
    logic [31:0] z, base;
    logic [32:0] rounded;
    dx = {{32{p.point_x[31]}}, p.point_x} - {{32{cx[31]}}, cx};
    dy = {{32{p.point_y[31]}}, p.point_y} - {{32{cy[31]}}, cy};
    z = '0;
    base = '0;
    if (dx == 0) begin
      // Straight up is a quarter turn; straight down and the center itself
      // both give three quarters.
      z = (dy > 0) ? fcpac_pkg::TURN_QUARTER : fcpac_pkg::TURN_3QUART;
    end else begin
      if (dx < 0) begin
        x = -dx;
        y = -dy;
        base = fcpac_pkg::TURN_HALF;
      end else begin
        x = dx;
        y = dy;
      end
      mag = (y < 0) ? -y : y;
      if (x > mag) mag = x;
      while (mag < 64'h0800_0000_0000_0000) begin
        mag = mag << 1;
        x = x << 1;
        y = y << 1;
      end
      for (int i = 0; i < fcpac_pkg::CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP[i];
        end
      end
    end
    rounded = {1'b0, base + z} + (33'd1 << (fcpac_pkg::ROUND_SH - 1));
    return rounded[fcpac_pkg::ROUND_SH +: fcpac_pkg::ANGLE_BITS];
  endfunction

  function automatic fcpac_pkg::out_beat_t classify_point(fcpac_pkg::in_beat_t p);
    fcpac_pkg::out_beat_t r;
    r.angle = point_angle(p, ctr_x, ctr_y);
    // With both arc ends on the same angle the start takes precedence.
    if (r.angle == arc_start) r.endpoint_class = fcpac_pkg::CLASS_INITIAL;
    else if (r.angle == arc_end) r.endpoint_class = fcpac_pkg::CLASS_TERMINAL;
    else r.endpoint_class = fcpac_pkg::CLASS_NONE;
    return r;
  endfunction

  function automatic logic [31:0] jitter(int span);
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [31:0] extreme_coord(logic [31:0] c);
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return c;
    endcase
  endfunction

  function automatic fcpac_pkg::in_beat_t rand_point(logic [31:0] cx, logic [31:0] cy,
                                                     fcpac_pkg::in_beat_t p1,
                                                     fcpac_pkg::in_beat_t p2);
    fcpac_pkg::in_beat_t p;
    case ($urandom_range(0, 9))
      0, 1: begin
        p.point_x = $urandom;
        p.point_y = $urandom;
      end
      2, 3: begin
        p.point_x = cx + jitter(1024);
        p.point_y = cy + jitter(1024);
      end
      4: begin
        p.point_x = cx;
        p.point_y = $urandom_range(0, 1) ? cy + jitter(64) : 32'($urandom);
      end
      5: begin
        p.point_x = $urandom_range(0, 1) ? cx + jitter(1 << 20) : 32'($urandom);
        p.point_y = cy;
      end
      6: begin
        // Just below the positive x axis, where rounding wraps to zero.
        p.point_x = cx + 32'($urandom_range(1, 32'h3FFF_FFFF));
        p.point_y = cy - 32'($urandom_range(1, 4));
      end
      7: p = p1;
      8: p = p2;
      default: begin
        p.point_x = extreme_coord(cx);
        p.point_y = extreme_coord(cy);
      end
    endcase
    return p;
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    fcpac_pkg::in_beat_t p;
    p.point_x = x;
    p.point_y = y;
    point_q.push_back(p);
  endtask

  task automatic write_reg(logic [fcpac_pkg::CFG_IDX_W-1:0] idx,
                           logic [fcpac_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      fcpac_pkg::CFG_CENTER_X:    ctr_x = val;
      fcpac_pkg::CFG_CENTER_Y:    ctr_y = val;
      fcpac_pkg::CFG_START_ANGLE: arc_start = val[15:0];
      fcpac_pkg::CFG_END_ANGLE:   arc_end = val[15:0];
    endcase
  endtask

  // Angle registers get random upper bits, which the block must drop.
  task automatic set_config(logic [31:0] cx, logic [31:0] cy, logic [15:0] sa,
                            logic [15:0] ea);
    write_reg(fcpac_pkg::CFG_CENTER_X, cx);
    write_reg(fcpac_pkg::CFG_CENTER_Y, cy);
    write_reg(fcpac_pkg::CFG_START_ANGLE, {16'($urandom), sa});
    write_reg(fcpac_pkg::CFG_END_ANGLE, {16'($urandom), ea});
  endtask

  task automatic wait_drained();
    while (point_q.size() != 0 || in_valid || angle_q.size() != 0) @(negedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic load;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) angle_q.push_back(classify_point(in_beat));
      if (!in_valid || in_ready) begin
        load = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (point_q.size() != 0) begin
          load = 1'b1;
          in_beat <= point_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= load;
      end
    end
  end

  // Receiver: checks each beat and stalls in one of several modes.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    fcpac_pkg::out_beat_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (angle_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected beat, angle %0d class %0d", $time, out_beat.angle,
                     out_beat.endpoint_class);
          mismatch_cnt++;
        end else begin
          want = angle_q.pop_front();
          if (out_beat.angle !== want.angle ||
              out_beat.endpoint_class !== want.endpoint_class) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch, expected angle %0d class %0d, got angle %0d class %0d",
                       $time, want.angle, want.endpoint_class, out_beat.angle,
                       out_beat.endpoint_class);
            mismatch_cnt++;
          end
        end
      end
      pat_cnt++;
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (pat_cnt % 8 >= 5);
      endcase
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("full_circle_point_angle_classify test failed");
    $finish;
  end

  initial begin : stimulus
    fcpac_pkg::in_beat_t p1, p2;
    logic [31:0] cx, cy;
    logic [15:0] sa, ea;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: center at the origin, both arc ends at zero.
    @(negedge clk_i);
    add_point(32'h0, 32'h0);
    add_point(32'h0, 32'h1);
    add_point(32'h0, 32'hFFFF_FFFF);
    add_point(32'hFFFF_FFFF, 32'h0);
    add_point(32'h5, 32'h0);
    add_point(COORD_MAX, COORD_MAX);
    add_point(COORD_MIN, COORD_MIN);
    add_point(COORD_MAX, COORD_MIN);
    add_point(COORD_MIN, COORD_MAX);
    add_point(32'h0, COORD_MAX);
    add_point(32'h0, COORD_MIN);
    add_point(COORD_MIN, 32'h0);
    add_point(COORD_MAX, 32'hFFFF_FFFF);

    // Center in a corner, arc ends on the vertical angles.
    wait_drained();
    set_config(COORD_MAX, COORD_MIN, 16'h4000, 16'hC000);
    @(negedge clk_i);
    add_point(COORD_MAX, COORD_MIN);
    add_point(COORD_MAX, COORD_MAX);
    add_point(COORD_MIN, COORD_MIN);
    add_point(COORD_MIN, COORD_MAX);
    add_point(COORD_MAX, 32'h8000_0001);

    // Both arc ends on the half turn.
    wait_drained();
    set_config(32'h0, 32'h0, 16'h8000, 16'h8000);
    @(negedge clk_i);
    add_point(32'hFFFF_FFFF, 32'h0);
    add_point(COORD_MIN, 32'h0);
    add_point(32'h3, 32'hFFFF_FFFD);
    add_point(32'h0, COORD_MIN);

    for (int k = 0; k < 10; k++) begin
      wait_drained();
      case ((k == 9) ? 2 : $urandom_range(0, 3))
        0: begin
          cx = 32'h0;
          cy = 32'h0;
        end
        1: begin
          cx = $urandom;
          cy = $urandom;
        end
        2: begin
          cx = extreme_coord(32'h0);
          cy = extreme_coord(32'h0);
        end
        default: begin
          cx = jitter(1 << 20);
          cy = jitter(1 << 20);
        end
      endcase
      p1.point_x = cx + jitter(4096);
      p1.point_y = cy + jitter(4096);
      p2.point_x = cx + jitter(4096);
      p2.point_y = cy + jitter(4096);
      // Arc ends are often put on angles that some points will hit.
      case (k % 4)
        0: begin
          sa = point_angle(p1, cx, cy);
          ea = point_angle(p2, cx, cy);
        end
        1: begin
          sa = point_angle(p1, cx, cy);
          ea = sa;
        end
        2: begin
          sa = 16'h0;
          ea = 16'hFFFF;
        end
        default: begin
          sa = 16'($urandom);
          ea = 16'($urandom);
        end
      endcase
      set_config(cx, cy, sa, ea);
      @(negedge clk_i);
      repeat (175) point_q.push_back(rand_point(cx, cy, p1, p2));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && angle_q.size() == 0) begin
      $display("full_circle_point_angle_classify test passed");
    end else begin
      $display("full_circle_point_angle_classify test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
